@@ src/smcb_pkg.sv @@
// Shared types and constants for the slide motor coast/brake controller.
package smcb_pkg;

    localparam int unsigned TIMER_WIDTH_DEF = 16;

    localparam int unsigned TV_W     = 20;   // target_voltage
    localparam int unsigned TOP_W    = 16;   // pwm_top, duty
    localparam int unsigned TICKS_W  = 16;   // coast_ticks
    localparam int unsigned SAMPLE_W = 16;   // supply_sample
    localparam int unsigned SCALE_W  = 7;    // tv/sample stays below 100 on the slow path
    localparam int unsigned PROD_W   = TOP_W + SCALE_W;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_VOLTAGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COAST_TICKS    = 3'd3;

    // requested motion codes
    localparam logic [1:0] MOTION_BACK = 2'd0;
    localparam logic [1:0] MOTION_FWD  = 2'd1;
    localparam logic [1:0] MOTION_IDLE = 2'd2;

    localparam logic [TOP_W-1:0] DIV_CONST   = 16'd100;
    localparam logic [TOP_W-1:0] ROUND_LIMIT = 16'd50;

    localparam logic [TV_W-1:0]  TV_RESET    = '0;
    localparam logic [TOP_W-1:0] TOP_RESET   = 16'hFFFF;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd10;

    typedef enum logic [1:0] {
        MODE_RUN   = 2'd0,
        MODE_COAST = 2'd1,
        MODE_BRAKE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CALC,
        T_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        D_IDLE,
        D_DIV,
        D_MUL,
        D_DIV100,
        D_ROUND
    } duty_state_t;

    typedef struct packed {
        logic             start;
        logic [TV_W-1:0]  target_voltage;
        logic [TOP_W-1:0] pwm_top;
        logic [SAMPLE_W-1:0] sample;
    } duty_req_t;

    typedef struct packed {
        logic             done;
        logic [TOP_W-1:0] duty;
    } duty_rsp_t;

endpackage

@@ src/smcb_duty.sv @@
// Bit-serial supply-compensated duty unit: divide, shift-add multiply, divide by 100, round.
module smcb_duty (
    input  logic               aclk,
    input  logic               aresetn,
    input  smcb_pkg::duty_req_t req,
    output smcb_pkg::duty_rsp_t rsp
);
    import smcb_pkg::*;

    duty_state_t state_reg, state_next;
    logic [TOP_W-1:0]  rem_reg,  rem_next;
    logic [TOP_W-1:0]  dvsr_reg, dvsr_next;
    logic [TOP_W-1:0]  dvd_reg,  dvd_next;
    logic [TOP_W-1:0]  quo_reg,  quo_next;
    logic [TOP_W-1:0]  top_reg,  top_next;
    logic [PROD_W-1:0] acc_reg,  acc_next;
    logic [3:0]        cnt_reg,  cnt_next;
    logic [TOP_W-1:0]  res_reg,  res_next;
    logic              done_reg, done_next;

    logic [TOP_W:0]    shifted;
    logic [TOP_W+1:0]  diff;
    logic              ge;
    logic [TOP_W-1:0]  step_rem;
    logic [TOP_W-1:0]  step_quo;
    logic [PROD_W-1:0] s100;
    logic [PROD_W-1:0] mul_acc;
    logic [TOP_W:0]    rounded;

    // one restoring step: bring in the next dividend bit, try a subtract
    always_comb begin
        shifted  = {rem_reg, dvd_reg[TOP_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvsr_reg};
        ge       = ~diff[TOP_W+1];
        step_rem = ge ? diff[TOP_W-1:0] : shifted[TOP_W-1:0];
        step_quo = {quo_reg[TOP_W-2:0], ge};
    end

    // sample * 100 = (s << 6) + (s << 5) + (s << 2)
    always_comb begin
        s100 = ({{(PROD_W-SAMPLE_W){1'b0}}, req.sample} << 6)
             + ({{(PROD_W-SAMPLE_W){1'b0}}, req.sample} << 5)
             + ({{(PROD_W-SAMPLE_W){1'b0}}, req.sample} << 2);
        mul_acc = {acc_reg[PROD_W-2:0], 1'b0}
                + (quo_reg[SCALE_W-1] ? {{(PROD_W-TOP_W){1'b0}}, top_reg} : '0);
        rounded = {1'b0, quo_reg} + {{TOP_W{1'b0}}, 1'b1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        top_reg  <= top_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        top_next   = top_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    top_next = req.pwm_top;
                    if (s100 <= {{(PROD_W-TV_W){1'b0}}, req.target_voltage}) begin
                        res_next  = req.pwm_top;
                        done_next = 1'b1;
                    end else begin
                        // quotient < 128, so the top 13 dividend bits start below the divisor
                        rem_next   = {{(TOP_W-(TV_W-SCALE_W)){1'b0}},
                                      req.target_voltage[TV_W-1:SCALE_W]};
                        dvd_next   = {req.target_voltage[SCALE_W-1:0], {(TOP_W-SCALE_W){1'b0}}};
                        dvsr_next  = req.sample;
                        quo_next   = '0;
                        cnt_next   = 4'(SCALE_W - 1);
                        state_next = D_DIV;
                    end
                end
            end
            D_DIV: begin
                rem_next = step_rem;
                dvd_next = {dvd_reg[TOP_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    // keep the 7-bit scale in the low bits; the multiply takes it MSB-first from bit 6
                    quo_next   = {step_quo[SCALE_W-1:0], {(TOP_W-SCALE_W){1'b0}}} >> (TOP_W-SCALE_W);
                    acc_next   = '0;
                    cnt_next   = 4'(SCALE_W - 1);
                    state_next = D_MUL;
                end else begin
                    quo_next = step_quo;
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            D_MUL: begin
                acc_next = mul_acc;
                quo_next = {quo_reg[TOP_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    // product < 100 * 2^16, so its top bits start below 100
                    rem_next   = {{(TOP_W-(PROD_W-TOP_W)){1'b0}}, mul_acc[PROD_W-1:TOP_W]};
                    dvd_next   = mul_acc[TOP_W-1:0];
                    dvsr_next  = DIV_CONST;
                    quo_next   = '0;
                    cnt_next   = 4'(TOP_W - 1);
                    state_next = D_DIV100;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            D_DIV100: begin
                rem_next = step_rem;
                quo_next = step_quo;
                dvd_next = {dvd_reg[TOP_W-2:0], 1'b0};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    state_next = D_ROUND;
                end
            end
            D_ROUND: begin
                if (rem_reg > ROUND_LIMIT) begin
                    res_next = rounded[TOP_W] ? '1 : rounded[TOP_W-1:0];
                end else begin
                    res_next = quo_reg;
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: state_next = D_IDLE;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.duty = res_reg;

endmodule

@@ src/slide_motor_coast_brake_control_core.sv @@
// Top level: handshakes, configuration, motor state and the coast/brake decision.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: motion, limits, fault, sample; s_tuser: action
//  m_      | out | m_tvalid/m_tready  | m_tdata: done, duty, phase, decay, pulse, mode
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick or a non-driving control transaction goes through T_EMIT into the output register.
// A drive request also waits in T_CALC on the bit-serial duty unit (7-step divide,
// 7-step multiply, 16-step divide by 100, then rounding).
// One transaction is in work at a time; the next is taken once the result sits in the
// output register, which holds it while m_tready is low. Synchronous active-low reset.
module slide_motor_coast_brake_control_core #(
    parameter int unsigned TIMER_WIDTH = smcb_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] requested_motion, [2] slide_back_limit, [3] slide_front_limit,
    // [4] back_down_limit, [5] back_up_limit, [6] driver_fault, [22:7] supply_sample
    input  logic [smcb_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] action
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] done_res, [16:1] pwm_duty, [17] phase_pin, [18] decay_pin,
    // [19] reset_pulse, [21:20] motor_mode
    output logic [smcb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [smcb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smcb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import smcb_pkg::*;

    localparam int unsigned CMP_W = (TIMER_WIDTH > TICKS_W) ? TIMER_WIDTH : TICKS_W;

    // configuration
    logic               enable_reg;
    logic [TV_W-1:0]    tv_reg;
    logic [TOP_W-1:0]   top_reg;
    logic [TICKS_W-1:0] ticks_reg;

    // motor state
    top_state_t             state_reg, state_next;
    mode_t                  mode_reg,  mode_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [TOP_W-1:0]       duty_reg,  duty_next;
    logic                   phase_reg, phase_next;
    logic                   decay_reg, decay_next;
    logic                   done_reg,  done_next;
    logic                   pulse_reg, pulse_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg,  m_data_next;

    duty_req_t duty_req;
    duty_rsp_t duty_rsp;

    logic [1:0]          motion;
    logic                back_lim, front_lim, bdown, bup, fault;
    logic [SAMPLE_W-1:0] sample;
    logic                accept;
    logic                stop_req;
    logic                drive_req;

    // brake procedure outcome from the current state
    mode_t                  brk_mode;
    logic                   brk_decay;
    logic [TIMER_WIDTH-1:0] brk_timer;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == T_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign motion    = s_tdata[1:0];
    assign back_lim  = s_tdata[2];
    assign front_lim = s_tdata[3];
    assign bdown     = s_tdata[4];
    assign bup       = s_tdata[5];
    assign fault     = s_tdata[6];
    assign sample    = s_tdata[22:7];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            tv_reg     <= TV_RESET;
            top_reg    <= TOP_RESET;
            ticks_reg  <= TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MOTOR_ENABLE:   enable_reg <= cfg_data[0];
                REG_TARGET_VOLTAGE: tv_reg     <= cfg_data[TV_W-1:0];
                REG_PWM_TOP:        top_reg    <= cfg_data[TOP_W-1:0];
                REG_COAST_TICKS:    ticks_reg  <= cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        brk_mode  = mode_reg;
        brk_decay = decay_reg;
        brk_timer = timer_reg;
        if (mode_reg == MODE_RUN) begin
            brk_mode  = MODE_COAST;
            brk_decay = 1'b1;
            brk_timer = '0;
        end
        if (!(brk_mode == MODE_COAST &&
              CMP_W'(brk_timer) < CMP_W'(ticks_reg))) begin
            brk_mode  = MODE_BRAKE;
            brk_decay = 1'b0;
        end
    end

    assign stop_req = !enable_reg || (bdown && bup) || (motion == MOTION_IDLE) ||
                      (motion == MOTION_BACK && back_lim) ||
                      (motion == MOTION_FWD && front_lim);
    assign drive_req = (motion == MOTION_BACK) || (motion == MOTION_FWD);

    assign duty_req.start          = accept && !s_tuser && !stop_req && drive_req;
    assign duty_req.target_voltage = tv_reg;
    assign duty_req.pwm_top        = top_reg;
    assign duty_req.sample         = sample;

    smcb_duty u_duty (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (duty_req),
        .rsp     (duty_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            mode_reg    <= MODE_BRAKE;
            timer_reg   <= '0;
            duty_reg    <= '0;
            phase_reg   <= 1'b0;
            decay_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            timer_reg   <= timer_next;
            duty_reg    <= duty_next;
            phase_reg   <= phase_next;
            decay_reg   <= decay_next;
            m_valid_reg <= m_valid_next;
        end
        done_reg   <= done_next;
        pulse_reg  <= pulse_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        timer_next   = timer_reg;
        duty_next    = duty_reg;
        phase_next   = phase_reg;
        decay_next   = decay_reg;
        done_next    = done_reg;
        pulse_next   = pulse_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    done_next  = 1'b0;
                    pulse_next = 1'b0;
                    state_next = T_EMIT;
                    if (s_tuser) begin
                        if (timer_reg != '1) begin
                            timer_next = timer_reg + 1'b1;
                        end
                    end else if (stop_req) begin
                        mode_next  = brk_mode;
                        decay_next = brk_decay;
                        timer_next = brk_timer;
                        duty_next  = '0;
                        done_next  = 1'b1;
                    end else if (drive_req) begin
                        phase_next = motion[0];
                        decay_next = 1'b0;
                        mode_next  = MODE_RUN;
                        pulse_next = fault;
                        state_next = T_CALC;
                    end else begin
                        duty_next = '0;
                    end
                end
            end
            T_CALC: begin
                if (duty_rsp.done) begin
                    duty_next  = duty_rsp.duty;
                    state_next = T_EMIT;
                end
            end
            T_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, mode_reg, pulse_reg, decay_reg, phase_reg,
                                    duty_reg, done_reg};
                    state_next   = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

endmodule

@@ sim/slide_motor_coast_brake_control_core_test.sv @@
// Testbench for the slide motor coast/brake controller: directed and random transactions.
module slide_motor_coast_brake_control_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smcb_pkg::*;

    localparam int unsigned TMR_W         = TIMER_WIDTH_DEF;
    localparam logic [1:0]  MOTION_UNKNOWN = 2'd3;
    localparam logic        ACT_CONTROL    = 1'b0;
    localparam logic        ACT_TICK       = 1'b1;
    localparam int unsigned CYCLE_LIMIT    = 4_000_000;
    localparam int unsigned RANDOM_ITEMS   = 1500;
    localparam int unsigned RANDOM_PHASES  = 8;

    typedef struct {
        logic                action;
        logic [1:0]          motion;
        logic                slide_back;
        logic                slide_front;
        logic                back_down;
        logic                back_up;
        logic                fault;
        logic [SAMPLE_W-1:0] sample;
    } motor_cmd_t;

    // matches m_tdata[21:0]
    typedef struct packed {
        logic [1:0]       mode;
        logic             pulse;
        logic             decay;
        logic             phase;
        logic [TOP_W-1:0] duty;
        logic             done;
    } motor_out_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted register and motor state
    logic               en_cfg;
    logic [TV_W-1:0]    tv_cfg;
    logic [TOP_W-1:0]   top_cfg;
    logic [TICKS_W-1:0] ticks_cfg;
    mode_t              mode_q;
    logic [TMR_W-1:0]   coast_tmr;
    logic [TOP_W-1:0]   duty_q;
    logic               phase_q;
    logic               decay_q;

    motor_out_t  expected_outputs[$];
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;

    slide_motor_coast_brake_control_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("slide_motor_coast_brake_control_core verification failed");
        $finish;
    end

    initial forever begin
        @(negedge aclk);
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------- predictor ----------------

    task automatic reset_model();
        en_cfg    = 1'b1;
        tv_cfg    = TV_RESET;
        top_cfg   = TOP_RESET;
        ticks_cfg = TICKS_RESET;
        mode_q    = MODE_BRAKE;
        coast_tmr = '0;
        duty_q    = '0;
        phase_q   = 1'b0;
        decay_q   = 1'b0;
    endtask

    // run goes to coast first; coast turns into brake once the timer reaches coast_ticks
    function automatic void brake_motor();
        duty_q = '0;
        if (mode_q == MODE_RUN) begin
            decay_q   = 1'b1;
            mode_q    = MODE_COAST;
            coast_tmr = '0;
        end
        if (!(mode_q == MODE_COAST && coast_tmr < ticks_cfg)) begin
            decay_q = 1'b0;
            mode_q  = MODE_BRAKE;
        end
    endfunction

    function automatic logic [TOP_W-1:0] compensated_duty(input logic [SAMPLE_W-1:0] sample);
        logic [63:0] prod;
        logic [63:0] quot;
        if (sample <= tv_cfg / DIV_CONST)
            return top_cfg;
        prod = 64'(top_cfg) * 64'(tv_cfg / sample);
        quot = prod / DIV_CONST;
        if (prod % DIV_CONST > ROUND_LIMIT)
            quot++;
        if (quot > 64'hFFFF)
            quot = 64'hFFFF;
        return quot[TOP_W-1:0];
    endfunction

    function automatic motor_out_t predict_motor(input motor_cmd_t c);
        motor_out_t r;
        r.done  = 1'b0;
        r.pulse = 1'b0;
        if (c.action == ACT_TICK) begin
            if (coast_tmr != '1)
                coast_tmr++;
        end else if (!en_cfg) begin
            brake_motor();
            r.done = 1'b1;
        end else if (c.back_down && c.back_up) begin
            brake_motor();
            r.done = 1'b1;
        end else if (c.motion == MOTION_IDLE || (c.motion == MOTION_BACK && c.slide_back) ||
                     (c.motion == MOTION_FWD && c.slide_front)) begin
            brake_motor();
            r.done = 1'b1;
        end else if (c.motion == MOTION_BACK || c.motion == MOTION_FWD) begin
            phase_q = c.motion[0];
            decay_q = 1'b0;
            duty_q  = compensated_duty(c.sample);
            r.pulse = c.fault;
            mode_q  = MODE_RUN;
        end else begin
            duty_q = '0;
        end
        r.duty  = duty_q;
        r.phase = phase_q;
        r.decay = decay_q;
        r.mode  = mode_q;
        return r;
    endfunction

    // ---------------- result checking ----------------

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got_v, want_v, $realtime);
        error_count++;
    endtask

    always @(posedge aclk) begin : check_results
        motor_out_t got;
        motor_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = motor_out_t'(m_tdata[21:0]);
            if (expected_outputs.size() == 0) begin
                report_mismatch("result transaction with nothing expected", got, 0);
            end else begin
                want = expected_outputs.pop_front();
                if (got.done !== want.done)
                    report_mismatch("done_res", got.done, want.done);
                if (got.duty !== want.duty)
                    report_mismatch("pwm_duty", got.duty, want.duty);
                if (got.phase !== want.phase)
                    report_mismatch("phase_pin", got.phase, want.phase);
                if (got.decay !== want.decay)
                    report_mismatch("decay_pin", got.decay, want.decay);
                if (got.pulse !== want.pulse)
                    report_mismatch("reset_pulse", got.pulse, want.pulse);
                if (got.mode !== want.mode)
                    report_mismatch("motor_mode", got.mode, want.mode);
            end
        end
    end

    // ---------------- drivers (called at the falling edge) ----------------

    task automatic send_cmd(input motor_cmd_t c);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = c.action;
        s_tdata  = {1'b0, c.sample, c.fault, c.back_up, c.back_down,
                    c.slide_front, c.slide_back, c.motion};
        do @(posedge aclk); while (!s_tready);
        expected_outputs.push_back(predict_motor(c));
        items_sent++;
        @(negedge aclk);
    endtask

    // lim = {back_up, back_down, slide_front, slide_back}
    task automatic send_ctrl(input logic [1:0] motion, input logic [3:0] lim, input logic fault,
                             input logic [SAMPLE_W-1:0] sample);
        motor_cmd_t c;
        c.action      = ACT_CONTROL;
        c.motion      = motion;
        c.slide_back  = lim[0];
        c.slide_front = lim[1];
        c.back_down   = lim[2];
        c.back_up     = lim[3];
        c.fault       = fault;
        c.sample      = sample;
        send_cmd(c);
    endtask

    // payload bits of a tick are don't-care, so they carry noise
    task automatic send_tick();
        motor_cmd_t c;
        c.action      = ACT_TICK;
        c.motion      = 2'($urandom);
        c.slide_back  = 1'($urandom);
        c.slide_front = 1'($urandom);
        c.back_down   = 1'($urandom);
        c.back_up     = 1'($urandom);
        c.fault       = 1'($urandom);
        c.sample      = SAMPLE_W'($urandom);
        send_cmd(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MOTOR_ENABLE:   en_cfg    = value[0];
            REG_TARGET_VOLTAGE: tv_cfg    = value[TV_W-1:0];
            REG_PWM_TOP:        top_cfg   = value[TOP_W-1:0];
            REG_COAST_TICKS:    ticks_cfg = value[TICKS_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (expected_outputs.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_all(input logic en, input logic [TV_W-1:0] tv,
                             input logic [TOP_W-1:0] top, input logic [TICKS_W-1:0] ticks);
        wait_idle();
        write_reg(REG_MOTOR_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_TARGET_VOLTAGE, CFG_DATA_W'(tv));
        write_reg(REG_PWM_TOP, CFG_DATA_W'(top));
        write_reg(REG_COAST_TICKS, CFG_DATA_W'(ticks));
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ---------------- random item shapes ----------------

    // spread samples around the compensation threshold
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned thr;
        thr = tv_cfg / DIV_CONST;
        case ($urandom_range(3))
            0:       return SAMPLE_W'($urandom);
            1:       return SAMPLE_W'(thr + $urandom_range(2));
            2:       return SAMPLE_W'($urandom_range(thr));
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    task automatic send_stop();
        logic [1:0] dir;
        dir = $urandom_range(1) ? MOTION_FWD : MOTION_BACK;
        case ($urandom_range(2))
            0:       send_ctrl(MOTION_IDLE, 4'($urandom), 1'($urandom), pick_sample());
            1:       send_ctrl(dir, (dir == MOTION_FWD) ? 4'b0010 : 4'b0001, 1'($urandom),
                               pick_sample());
            default: send_ctrl(2'($urandom), 4'b1100, 1'($urandom), pick_sample());
        endcase
    endtask

    // drive, stop into coast, tick through it, stop again
    task automatic send_run_sequence();
        int unsigned n_drive;
        int unsigned n_tick;
        logic [1:0]  dir;
        logic [3:0]  lim;
        n_drive = $urandom_range(1, 3);
        repeat (n_drive) begin
            dir = $urandom_range(1) ? MOTION_FWD : MOTION_BACK;
            lim = '0;
            // only the limit opposite the motion, and at most one backrest limit
            if (dir == MOTION_FWD)
                lim[0] = 1'($urandom);
            else
                lim[1] = 1'($urandom);
            case ($urandom_range(3))
                0:       lim[2] = 1'b1;
                1:       lim[3] = 1'b1;
                default: ;
            endcase
            send_ctrl(dir, lim, $urandom_range(99) < 20, pick_sample());
        end
        send_stop();
        n_tick = (ticks_cfg + 2 < 8) ? ticks_cfg + 2 : 8;
        n_tick = $urandom_range(n_tick);
        repeat (n_tick) send_tick();
        send_stop();
    endtask

    task automatic send_noise();
        motor_cmd_t c;
        c.action      = 1'($urandom);
        c.motion      = 2'($urandom);
        c.slide_back  = 1'($urandom);
        c.slide_front = 1'($urandom);
        c.back_down   = 1'($urandom);
        c.back_up     = 1'($urandom);
        c.fault       = 1'($urandom);
        c.sample      = SAMPLE_W'($urandom);
        send_cmd(c);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_values();
        send_tick();
        send_ctrl(MOTION_FWD, 4'b0000, 1'b0, 16'd0);       // full top from reset
        send_ctrl(MOTION_BACK, 4'b0000, 1'b0, 16'd1);      // zero target gives zero duty
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd0);      // coast held by default ticks
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd0);
    endtask

    task automatic test_duty_compensation();
        write_all(1'b1, 20'hFFFFF, 16'hFFFF, 16'd2);
        send_ctrl(MOTION_FWD, 4'b0000, 1'b1, 16'd0);
        send_ctrl(MOTION_FWD, 4'b0000, 1'b0, 16'd10485);   // exactly at threshold
        send_ctrl(MOTION_FWD, 4'b0000, 1'b0, 16'd10486);   // just above, rounds up
        send_ctrl(MOTION_BACK, 4'b0000, 1'b0, 16'hFFFF);
        send_ctrl(MOTION_BACK, 4'b0000, 1'b1, 16'd333);
    endtask

    task automatic test_coast_brake();
        send_ctrl(MOTION_BACK, 4'b0001, 1'b0, 16'd500);    // run -> coast
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd500);
        send_tick();
        send_tick();
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd500);    // timer reached ticks -> brake
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd500);
        write_all(1'b1, 20'hFFFFF, 16'hFFFF, 16'd0);
        send_ctrl(MOTION_FWD, 4'b0000, 1'b0, 16'd20000);
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd20000);  // zero ticks: run to brake at once
    endtask

    task automatic test_limits_and_fault();
        send_ctrl(MOTION_FWD, 4'b0010, 1'b1, 16'd1000);
        send_ctrl(MOTION_FWD, 4'b0001, 1'b1, 16'd1000);
        send_ctrl(MOTION_BACK, 4'b0010, 1'b0, 16'd12000);
        send_ctrl(MOTION_FWD, 4'b1100, 1'b1, 16'd1000);    // both backrest limits
        send_ctrl(MOTION_BACK, 4'b0100, 1'b1, 16'd1000);
    endtask

    task automatic test_disable_and_unknown();
        send_ctrl(MOTION_UNKNOWN, 4'b0000, 1'b1, 16'd1000);
        write_all(1'b0, 20'hFFFFF, 16'hFFFF, 16'd3);
        send_ctrl(MOTION_FWD, 4'b0000, 1'b0, 16'd0);
        send_ctrl(MOTION_FWD, 4'b0000, 1'b1, 16'd0);
        write_all(1'b1, 20'd0, 16'd0, 16'd3);
        send_ctrl(MOTION_FWD, 4'b0000, 1'b0, 16'd0);       // zero top
        send_ctrl(MOTION_UNKNOWN, 4'b1111, 1'b1, 16'hFFFF);
    endtask

    // a large coast_ticks keeps the motor coasting across many ticks
    task automatic test_long_coast();
        set_idling(0, 0);
        write_all(1'b1, 20'd0, 16'hFFFF, 16'hFFFF);
        send_ctrl(MOTION_FWD, 4'b0000, 1'b0, 16'd0);
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd0);
        repeat (20) send_tick();
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd0);      // still coasting
        write_all(1'b1, 20'd0, 16'hFFFF, 16'd20);
        send_ctrl(MOTION_IDLE, 4'b0000, 1'b0, 16'd0);      // timer reached ticks -> brake
    endtask

    task automatic test_random_traffic();
        int unsigned quota;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_all((p == 5) ? 1'b0 : 1'b1,
                      (p == 0) ? 20'd0 : (p == 1) ? 20'hFFFFF : 20'($urandom),
                      (p == 2) ? 16'd0 : (p == 3) ? 16'hFFFF : 16'($urandom),
                      (p == 4) ? 16'd0 : 16'($urandom_range(1, 6)));
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(54, 0);
                2:       set_idling(0, 54);
                default: set_idling(7, 7);
            endcase
            quota = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < quota) begin
                if ($urandom_range(99) < 70)
                    send_run_sequence();
                else
                    send_noise();
            end
        end
    endtask

    initial begin
        reset_model();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_values();
        test_duty_compensation();
        test_coast_brake();
        test_limits_and_fault();
        test_disable_and_unknown();
        test_long_coast();
        test_random_traffic();

        wait_idle();
        repeat (50) @(negedge aclk);
        if (error_count == 0) begin
            $display("slide_motor_coast_brake_control_core verification clean");
        end else begin
            $display("slide_motor_coast_brake_control_core verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/smcb_pkg.sv
src/smcb_duty.sv
src/slide_motor_coast_brake_control_core.sv
sim/slide_motor_coast_brake_control_core_test.sv
